// File: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue core: request and result
// items, operation codes, status codes and the controller command group.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Operation codes carried in a request item
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

   // Status codes carried in a result item
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Width of the reported occupancy
   localparam int OCC_W = 5;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
      logic [1:0]         status;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the request item
      logic execute;  // access the store and update pointers
   } cmd_type;

endpackage

// File: src/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words held in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   A request item (req_data: opcode, push_value) is taken at a rising edge
//   where start is high and busy is low. Each request gives one result item
//   on rsp_data, shown for exactly one cycle with rsp_valid high.
//   The result follows the accepting edge through an execute state, in
//   which the store is written or read, and then a result state.
//   A new item may be accepted during the result cycle, and busy is high
//   only during the execute cycle, since the single store port is used then.
//   The receiver cannot hold results off; each result is taken in the cycle
//   it is shown.
//   Reset (synchronous, active high) empties the queue: pointers and count
//   go to zero and no result is pending. Store contents are not cleared and
//   are never shown in a result before being written.
//   Pops and peeks on an empty queue report status empty; pushes into a full
//   queue report status full and drop the word.
// ----------------------------------------------------------------------------
module double_ended_queue_core
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer of the double-ended queue: accepts a request, runs one execute
// cycle in the datapath and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module dq_ctrl
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // Accept while idle or while the previous result is being shown
   assign busy      = (state_ff == S_EXEC);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == S_RESP);

   assign cmd.load    = accept;
   assign cmd.execute = (state_ff == S_EXEC);

   // Advance the state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = accept ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Circular store, head/tail pointers, entry count and result registers of
// the double-ended queue.
// ----------------------------------------------------------------------------
module dq_datapath
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [31:0]        mem [DEPTH];
   req_type            req_ff;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        rd_data_ff;
   logic               rd_sel_ff;
   logic [1:0]         status_ff, status_in;
   logic [OCC_W-1:0]   occ_ff;
   logic               empty_ff;
   logic [CW+OCC_W-1:0] occ_wide;
   logic [AW-1:0]      head_prev, head_next, tail_prev, tail_next;
   logic [AW-1:0]      addr;
   logic               is_full, is_empty_now;
   logic               is_push, is_read;
   logic               do_write, do_read;

   // Wrap pointers around the store
   assign head_prev = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_SLOT : tail_ff - AW'(1);
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);

   assign is_full      = (count_ff == FULL_COUNT);
   assign is_empty_now = (count_ff == '0);

   // Decode the operation and pick the single store address
   always_comb begin
      is_push   = 1'b0;
      is_read   = 1'b0;
      addr      = head_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      case (req_ff.opcode)
         OP_PUSH_FRONT: begin
            is_push = 1'b1;
            addr    = head_prev;
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               head_in  = head_prev;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH_BACK: begin
            is_push = 1'b1;
            addr    = tail_ff;
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               tail_in  = tail_next;
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_FRONT: begin
            is_read = 1'b1;
            addr    = head_ff;
            if (is_empty_now) begin
               status_in = ST_EMPTY;
            end else begin
               head_in  = head_next;
               count_in = count_ff - CW'(1);
            end
         end
         OP_POP_BACK: begin
            is_read = 1'b1;
            addr    = tail_prev;
            if (is_empty_now) begin
               status_in = ST_EMPTY;
            end else begin
               tail_in  = tail_prev;
               count_in = count_ff - CW'(1);
            end
         end
         OP_PEEK_FRONT: begin
            is_read = 1'b1;
            addr    = head_ff;
            if (is_empty_now) status_in = ST_EMPTY;
         end
         OP_PEEK_BACK: begin
            is_read = 1'b1;
            addr    = tail_prev;
            if (is_empty_now) status_in = ST_EMPTY;
         end
         default: begin
            // unused opcodes leave everything as is
         end
      endcase
   end

   assign do_write = is_push && !is_full;
   assign do_read  = is_read && !is_empty_now;
   assign occ_wide = {{OCC_W{1'b0}}, count_in};

   // Capture the request item
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // Store access: one address, registered read data
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (do_write) mem[addr] <= req_ff.push_value;
         rd_data_ff <= mem[addr];
      end
   end

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Hold the result fields for the response cycle
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_sel_ff <= do_read;
         status_ff <= status_in;
         occ_ff    <= occ_wide[OCC_W-1:0];
         empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_data.read_value = rd_sel_ff ? rd_data_ff : '0;
   assign rsp_data.occupancy  = occ_ff;
   assign rsp_data.is_empty   = empty_ff;
   assign rsp_data.status     = status_ff;

endmodule

// File: src/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue core, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker
   import dq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // An accepted item occupies the store port in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // Every accepted item gives its result after its execute cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("result missing two cycles after accept");

   // Results never come in back-to-back cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Failed requests read back zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> (rsp_data.read_value == '0))
      else $error("nonzero read value on failed request");

   // An empty queue reports no occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> (rsp_data.occupancy == '0))
      else $error("empty flag with nonzero occupancy");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
